### hw/rtl/segfb_pkg.sv
// ----------------------------------------------------------------------------
// segfb_pkg
// Shared types and constants of the segment frame builder.
// ----------------------------------------------------------------------------
package segfb_pkg;

    // Configuration register indexes and reset values.
    localparam logic [1:0]  REG_LENGTH_RECIP = 2'd0;
    localparam logic [1:0]  REG_MIN_LENGTH   = 2'd1;
    localparam logic [1:0]  REG_AXIS_SWITCH  = 2'd2;
    localparam logic [15:0] LENGTH_RECIP_RST = 16'd6554;
    localparam logic [15:0] MIN_LENGTH_RST   = 16'd1;
    localparam logic [14:0] AXIS_SWITCH_RST  = 15'd14746;
    localparam int          RECIP_FRAC       = 16;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SQ,
        CMD_ROOT,
        CMD_DIV,
        CMD_PICK,
        CMD_CROSS,
        CMD_SPAN,
        CMD_EMIT
    } cmd_op_t;

    // Vector an operation works on: segment, unnormalized side, raw up.
    typedef enum logic [1:0] {
        VS_D,
        VS_C,
        VS_R
    } vsrc_t;

    // Use of a product in the cycle after the multiply.
    typedef enum logic [2:0] {
        PK_NONE,
        PK_SQ,
        PK_XA,
        PK_XB,
        PK_SPAN
    } pend_kind_t;

    typedef struct packed {
        cmd_op_t    op;
        vsrc_t      vsrc;
        logic [2:0] sel;
    } dp_cmd_t;

    typedef struct packed {
        logic busy;
        logic start;
        logic len_ok;
        logic out_busy;
    } dp_stat_t;

endpackage

### hw/rtl/segment_frame_builder.sv
// ----------------------------------------------------------------------------
// segment_frame_builder
// A segment node is taken while the sequencer is idle and is stepped through
// squares, square roots, divisions, cross products and span products before
// the frame beat is loaded into the output register. Rope starts and short
// segments return to idle without a frame. A stalled output beat
// holds the sequencer, so one node is in flight at a time.
// Reset clears the sequencer, the node history and the configuration.
// ----------------------------------------------------------------------------
module segment_frame_builder #(
    parameter int COORD_WIDTH    = 23,
    parameter int UNIT_FRAC_BITS = 14
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // node_x, node_y, node_z
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    // rope_start
    input  logic s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // origin_x/y/z, side_x/y/z, span_x/y/z, up_x/y/z
    output logic [((6*COORD_WIDTH+6*UNIT_FRAC_BITS+15+7)/8)*8-1:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import segfb_pkg::*;

    localparam int FW = 6 * COORD_WIDTH + 6 * UNIT_FRAC_BITS + 15;
    localparam int OW = ((FW + 7) / 8) * 8;

    dp_cmd_t        cmd;
    dp_stat_t       stat;
    logic [FW-1:0]  frame;

    segfb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    segfb_dp #(
        .CW (COORD_WIDTH),
        .F  (UNIT_FRAC_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .node_in    (s_tdata[3*COORD_WIDTH-1:0]),
        .rope_start (s_tuser),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (frame)
    );

    assign m_tdata = OW'(frame);

endmodule

### hw/rtl/segfb_ctrl.sv
// ----------------------------------------------------------------------------
// segfb_ctrl
// Sequencer that steps the datapath through one node.
// ----------------------------------------------------------------------------
module segfb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  segfb_pkg::dp_stat_t stat,
    output segfb_pkg::dp_cmd_t  cmd
);
    import segfb_pkg::*;

    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_CHECK = 15'b000000000000010,
        S_SQ    = 15'b000000000000100,
        S_SQW   = 15'b000000000001000,
        S_ROOT  = 15'b000000000010000,
        S_RWAIT = 15'b000000000100000,
        S_LCHK  = 15'b000000001000000,
        S_DIV   = 15'b000000010000000,
        S_DWAIT = 15'b000000100000000,
        S_PICK  = 15'b000001000000000,
        S_CROSS = 15'b000010000000000,
        S_CRW   = 15'b000100000000000,
        S_SPAN  = 15'b001000000000000,
        S_SPW   = 15'b010000000000000,
        S_EMIT  = 15'b100000000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    vsrc_t      vs_reg, vs_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        vs_next    = vs_reg;
        cmd.op     = CMD_NONE;
        cmd.vsrc   = vs_reg;
        cmd.sel    = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = CMD_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                vs_next  = VS_D;
                cnt_next = 3'd0;
                state_next = stat.start ? S_IDLE : S_SQ;
            end
            S_SQ:
            begin
                cmd.op = CMD_SQ;
                if (cnt_reg == 3'd2)
                begin
                    cnt_next   = 3'd0;
                    state_next = S_SQW;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            S_SQW:
            begin
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                cmd.op     = CMD_ROOT;
                state_next = S_RWAIT;
            end
            S_RWAIT:
            begin
                if (!stat.busy)
                begin
                    cnt_next   = 3'd0;
                    state_next = (vs_reg == VS_D) ? S_LCHK : S_DIV;
                end
            end
            S_LCHK:
            begin
                state_next = stat.len_ok ? S_DIV : S_IDLE;
            end
            S_DIV:
            begin
                cmd.op     = CMD_DIV;
                state_next = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (!stat.busy)
                begin
                    if (cnt_reg == 3'd2)
                    begin
                        cnt_next = 3'd0;
                        unique case (vs_reg)
                            VS_D:    state_next = S_PICK;
                            VS_C:    state_next = S_CROSS;
                            default: state_next = S_SPAN;
                        endcase
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + 3'd1;
                        state_next = S_DIV;
                    end
                end
            end
            S_PICK:
            begin
                cmd.op     = CMD_PICK;
                vs_next    = VS_C;
                state_next = S_SQ;
            end
            S_CROSS:
            begin
                cmd.op = CMD_CROSS;
                if (cnt_reg == 3'd5)
                begin
                    cnt_next   = 3'd0;
                    state_next = S_CRW;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            S_CRW:
            begin
                vs_next    = VS_R;
                state_next = S_SQ;
            end
            S_SPAN:
            begin
                cmd.op = CMD_SPAN;
                if (cnt_reg == 3'd2)
                begin
                    cnt_next   = 3'd0;
                    state_next = S_SPW;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            S_SPW:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.op     = CMD_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= 3'd0;
            vs_reg    <= VS_D;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            vs_reg    <= vs_next;
        end
    end

endmodule

### hw/rtl/segfb_dp.sv
// ----------------------------------------------------------------------------
// segfb_dp
// Datapath: node registers, shared multiplier, bit-serial square root,
// restoring divider, configuration registers and the output register.
// ----------------------------------------------------------------------------
module segfb_dp #(
    parameter int CW = 23,
    parameter int F  = 14
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  segfb_pkg::dp_cmd_t      cmd,
    output segfb_pkg::dp_stat_t     stat,
    input  logic                    cfg_wr_en,
    input  logic [1:0]              cfg_index,
    input  logic [15:0]             cfg_data,
    input  logic [3*CW-1:0]         node_in,
    input  logic                    rope_start,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [6*CW+6*F+14:0]    out_data
);
    import segfb_pkg::*;

    localparam int DW  = CW + 1;
    localparam int UW  = F + 2;
    localparam int RDW = F + 3;
    localparam int MW0 = (DW > RDW) ? DW : RDW;
    localparam int MW  = (MW0 > 17) ? MW0 : 17;
    localparam int PW  = 2 * MW;
    localparam int XW  = PW + 1;
    localparam int SW  = ((2 * CW + 2) > (2 * F + 4)) ? (2 * CW + 2) : (2 * F + 4);
    localparam int RW  = SW / 2;
    localparam int QN  = RW + F + 1;
    localparam int RCW = $clog2(RW + 1);
    localparam int DCW = $clog2(F + 2);

    // Configuration.
    logic [15:0] lr_reg, ml_reg;
    logic [14:0] as_reg;

    // Node and frame state.
    logic signed [CW-1:0]  prev_reg [3];
    logic signed [CW-1:0]  org_reg  [3];
    logic                  have_prev_reg, start_reg;
    logic signed [DW-1:0]  d_reg    [3];
    logic signed [UW-1:0]  a_reg    [3];
    logic signed [UW-1:0]  side_reg [3];
    logic signed [UW-1:0]  up_reg   [3];
    logic signed [RDW-1:0] r_reg    [3];
    logic signed [DW-1:0]  span_reg [3];
    logic [RW-1:0]         len_reg, ns_reg, nr_reg;
    logic                  usex_reg;
    logic signed [DW-1:0]  c_vec    [3];

    // Multiplier.
    logic signed [MW-1:0]  ma, mb, sq_v;
    logic signed [PW-1:0]  prod_reg;
    pend_kind_t            pk_reg;
    logic [1:0]            ps_reg;
    logic signed [XW-1:0]  xt_reg;
    logic [SW-1:0]         acc_reg;

    // Square root unit.
    logic [SW-1:0]         xs_reg;
    logic [RW+1:0]         rem_reg;
    logic [RW-1:0]         root_reg, root_next;
    logic [RCW-1:0]        rcnt_reg;
    vsrc_t                 rvs_reg;
    logic [RW+3:0]         tr, trial;
    logic                  rge;

    // Divider.
    logic [QN-1:0]         drem_reg, dsor_reg;
    logic [F:0]            q_reg, q_next;
    logic [DCW-1:0]        dcnt_reg;
    logic                  dneg_reg, dzero_reg;
    vsrc_t                 dvs_reg;
    logic [1:0]            dsel_reg;
    logic signed [MW-1:0]  dv_s;
    logic [MW-1:0]         dv_mag;
    logic [RW-1:0]         den;
    logic                  dge;
    logic signed [UW-1:0]  dres;

    // Product rounding.
    logic signed [XW-1:0]  xdiff;
    logic [XW-1:0]         xmag, xq;
    logic signed [RDW-1:0] rnew;
    logic [PW-1:0]         smag, sq;
    logic signed [DW-1:0]  snew;
    logic [UW-2:0]         amagz;

    logic                  out_valid_reg;
    logic [6*CW+6*F+14:0]  out_data_reg;

    logic [1:0] si;
    assign si = cmd.sel[1:0];

    always_comb
    begin
        if (usex_reg)
        begin
            c_vec[0] = '0;
            c_vec[1] = -d_reg[2];
            c_vec[2] = d_reg[1];
        end
        else
        begin
            c_vec[0] = -d_reg[1];
            c_vec[1] = d_reg[0];
            c_vec[2] = '0;
        end
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        unique case (cmd.vsrc)
            VS_D:    sq_v = MW'(d_reg[si]);
            VS_C:    sq_v = MW'(c_vec[si]);
            default: sq_v = MW'(r_reg[si]);
        endcase
        ma = '0;
        mb = '0;
        case (cmd.op)
            CMD_SQ:
            begin
                ma = sq_v;
                mb = sq_v;
            end
            CMD_CROSS:
            begin
                unique case (cmd.sel)
                    3'd0:    begin ma = MW'(side_reg[1]); mb = MW'(a_reg[2]); end
                    3'd1:    begin ma = MW'(side_reg[2]); mb = MW'(a_reg[1]); end
                    3'd2:    begin ma = MW'(side_reg[2]); mb = MW'(a_reg[0]); end
                    3'd3:    begin ma = MW'(side_reg[0]); mb = MW'(a_reg[2]); end
                    3'd4:    begin ma = MW'(side_reg[0]); mb = MW'(a_reg[1]); end
                    3'd5:    begin ma = MW'(side_reg[1]); mb = MW'(a_reg[0]); end
                    default: begin ma = '0; mb = '0; end
                endcase
            end
            CMD_SPAN:
            begin
                ma = MW'(d_reg[si]);
                mb = MW'($signed({1'b0, lr_reg}));
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    // Divider operand selection.
    always_comb
    begin
        unique case (cmd.vsrc)
            VS_D:
            begin
                dv_s = MW'(d_reg[si]);
                den  = len_reg;
            end
            VS_C:
            begin
                dv_s = MW'(c_vec[si]);
                den  = ns_reg;
            end
            default:
            begin
                dv_s = MW'(r_reg[si]);
                den  = nr_reg;
            end
        endcase
        dv_mag = dv_s[MW-1] ? MW'(-dv_s) : MW'(dv_s);
    end

    // One square root digit per cycle.
    assign tr        = {rem_reg, xs_reg[SW-1 -: 2]};
    assign trial     = {2'b00, root_reg, 2'b01};
    assign rge       = (tr >= trial);
    assign root_next = {root_reg[RW-2:0], rge};

    // One quotient bit per cycle.
    assign dge    = (drem_reg >= dsor_reg);
    assign q_next = {q_reg[F-1:0], dge};
    always_comb
    begin
        if (dzero_reg)
            dres = '0;
        else if (dneg_reg)
            dres = -UW'(q_next);
        else
            dres = UW'(q_next);
    end

    // Cross term difference rounded by 2^F, span rounded by 2^16.
    always_comb
    begin
        xdiff = xt_reg - XW'(prod_reg);
        xmag  = xdiff[XW-1] ? XW'(-xdiff) : XW'(xdiff);
        xq    = (xmag + (XW'(1) << (F - 1))) >> F;
        rnew  = xdiff[XW-1] ? -RDW'(xq) : RDW'(xq);
        smag  = prod_reg[PW-1] ? PW'(-prod_reg) : PW'(prod_reg);
        sq    = (smag + (PW'(1) << (RECIP_FRAC - 1))) >> RECIP_FRAC;
        // The quotient stays below the segment magnitude, so no clipping occurs.
        snew  = prod_reg[PW-1] ? -DW'(sq) : DW'(sq);
        amagz = a_reg[2][UW-1] ? (UW-1)'(-a_reg[2]) : (UW-1)'(a_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg        <= LENGTH_RECIP_RST;
            ml_reg        <= MIN_LENGTH_RST;
            as_reg        <= AXIS_SWITCH_RST;
            have_prev_reg <= 1'b0;
            pk_reg        <= PK_NONE;
            rcnt_reg      <= '0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
                prev_reg[i] <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_LENGTH_RECIP: lr_reg <= cfg_data;
                    REG_MIN_LENGTH:   ml_reg <= cfg_data;
                    REG_AXIS_SWITCH:  as_reg <= cfg_data[14:0];
                    default:          ;
                endcase
            end
            if (cmd.op == CMD_LOAD)
            begin
                have_prev_reg <= 1'b1;
                for (int i = 0; i < 3; i++)
                    prev_reg[i] <= node_in[i*CW +: CW];
            end
            case (cmd.op)
                CMD_SQ:    pk_reg <= PK_SQ;
                CMD_CROSS: pk_reg <= cmd.sel[0] ? PK_XB : PK_XA;
                CMD_SPAN:  pk_reg <= PK_SPAN;
                default:   pk_reg <= PK_NONE;
            endcase
            if (cmd.op == CMD_ROOT)
                rcnt_reg <= RCW'(RW);
            else if (rcnt_reg != '0)
                rcnt_reg <= rcnt_reg - RCW'(1);
            if (cmd.op == CMD_DIV)
                dcnt_reg <= DCW'(F + 1);
            else if (dcnt_reg != '0)
                dcnt_reg <= dcnt_reg - DCW'(1);
            if (cmd.op == CMD_EMIT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == CMD_LOAD)
        begin
            start_reg <= rope_start | ~have_prev_reg;
            for (int i = 0; i < 3; i++)
            begin
                org_reg[i] <= prev_reg[i];
                d_reg[i]   <= DW'($signed(node_in[i*CW +: CW])) - DW'(prev_reg[i]);
            end
        end
        if (cmd.op == CMD_PICK)
            usex_reg <= (32'(amagz) >= 32'(as_reg));

        prod_reg <= ma * mb;
        ps_reg   <= (cmd.op == CMD_CROSS) ? cmd.sel[2:1] : si;
        case (pk_reg)
            PK_SQ:   acc_reg <= (ps_reg == 2'd0) ? prod_reg[SW-1:0]
                                                 : acc_reg + prod_reg[SW-1:0];
            PK_XA:   xt_reg <= XW'(prod_reg);
            PK_XB:   r_reg[ps_reg] <= rnew;
            PK_SPAN: span_reg[ps_reg] <= snew;
            default: ;
        endcase

        if (cmd.op == CMD_ROOT)
        begin
            xs_reg   <= acc_reg;
            rem_reg  <= '0;
            root_reg <= '0;
            rvs_reg  <= cmd.vsrc;
        end
        else if (rcnt_reg != '0)
        begin
            xs_reg   <= xs_reg << 2;
            rem_reg  <= rge ? (RW+2)'(tr - trial) : (RW+2)'(tr);
            root_reg <= root_next;
            if (rcnt_reg == RCW'(1))
            begin
                unique case (rvs_reg)
                    VS_D:    len_reg <= root_next;
                    VS_C:    ns_reg  <= root_next;
                    default: nr_reg  <= root_next;
                endcase
            end
        end

        if (cmd.op == CMD_DIV)
        begin
            drem_reg  <= (QN'(dv_mag) << F) + QN'(den >> 1);
            dsor_reg  <= QN'(den) << F;
            q_reg     <= '0;
            dneg_reg  <= dv_s[MW-1];
            dzero_reg <= (den == '0);
            dvs_reg   <= cmd.vsrc;
            dsel_reg  <= si;
        end
        else if (dcnt_reg != '0)
        begin
            drem_reg <= dge ? drem_reg - dsor_reg : drem_reg;
            dsor_reg <= dsor_reg >> 1;
            q_reg    <= q_next;
            if (dcnt_reg == DCW'(1))
            begin
                unique case (dvs_reg)
                    VS_D:    a_reg[dsel_reg]    <= dres;
                    VS_C:    side_reg[dsel_reg] <= dres;
                    default: up_reg[dsel_reg]   <= dres;
                endcase
            end
        end

        if (cmd.op == CMD_EMIT)
            out_data_reg <= {up_reg[2], up_reg[1], up_reg[0],
                             span_reg[2], span_reg[1], span_reg[0],
                             side_reg[2], side_reg[1], side_reg[0],
                             org_reg[2], org_reg[1], org_reg[0]};
    end

    assign stat.busy     = (rcnt_reg != '0) || (dcnt_reg != '0);
    assign stat.start    = start_reg;
    assign stat.len_ok   = (len_reg != '0) && (len_reg >= RW'(ml_reg));
    assign stat.out_busy = out_valid_reg & ~out_ready;
    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment frame builder testbench
// Streams rope nodes into the block, predicts each placement frame with a
// behavioral model of the segment geometry, and checks every output beat
// field by field. Several register settings are covered, and both stream
// sides idle at random, with one long output stall.
// ----------------------------------------------------------------------------
module testbench;
    import segfb_pkg::*;

    localparam int CW       = 23;
    localparam int UF       = 14;
    localparam int IN_W     = ((3*CW+7)/8)*8;
    localparam int OUT_W    = ((6*CW+6*UF+15+7)/8)*8;
    localparam int SETTLE   = 300;
    localparam int LIMIT    = 2000000;
    localparam longint CMAX = 4194303;
    localparam longint CMIN = -4194304;

    typedef struct packed {
        bit [2:0][CW-1:0] org;
        bit [2:0][UF+1:0] side;
        bit [2:0][CW:0]   span;
        bit [2:0][UF+1:0] up;
    } frame_t;

    class frame_scoreboard;
        frame_t  pending_frames[$];
        longint  last_x, last_y, last_z;
        bit      has_last;
        longint  recip, min_len, switch_lim;
        int      errors;
        int      frames_checked;
        int      nodes_seen;

        function new();
            last_x = 0; last_y = 0; last_z = 0; has_last = 0;
            recip = LENGTH_RECIP_RST;
            min_len = MIN_LENGTH_RST;
            switch_lim = AXIS_SWITCH_RST;
            errors = 0; frames_checked = 0; nodes_seen = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] val);
            if (idx == REG_LENGTH_RECIP) recip = val;
            else if (idx == REG_MIN_LENGTH) min_len = val;
            else if (idx == REG_AXIS_SWITCH) switch_lim = val[14:0];
        endfunction

        function longint round_div(longint num, longint den);
            longint q;
            q = ((num < 0 ? -num : num) + den / 2) / den;
            return num < 0 ? -q : q;
        endfunction

        function longint root(longint v);
            longint lo, hi, m;
            lo = 0;
            hi = longint'(1) << 26;
            while (hi - lo > 1) begin
                m = lo + ((hi - lo) >> 1);
                if (m * m <= v) lo = m;
                else hi = m;
            end
            return lo;
        endfunction

        function void note_node(logic [IN_W-1:0] data, logic start_flag);
            longint nx, ny, nz, len, ns, nr, s;
            longint d[3], a[3], c[3], sd[3], r[3], u[3];
            bit     seg_start;
            frame_t f;
            nx = longint'($signed(data[0+:CW]));
            ny = longint'($signed(data[CW+:CW]));
            nz = longint'($signed(data[2*CW+:CW]));
            nodes_seen++;
            seg_start = start_flag || !has_last;
            d[0] = nx - last_x; d[1] = ny - last_y; d[2] = nz - last_z;
            f.org[0] = last_x[CW-1:0];
            f.org[1] = last_y[CW-1:0];
            f.org[2] = last_z[CW-1:0];
            last_x = nx; last_y = ny; last_z = nz;
            has_last = 1;
            if (seg_start) return;
            len = root(d[0]*d[0] + d[1]*d[1] + d[2]*d[2]);
            if (len == 0 || len < min_len) return;
            for (int i = 0; i < 3; i++) a[i] = round_div(d[i] * (1 << UF), len);
            if ((a[2] < 0 ? -a[2] : a[2]) >= switch_lim) begin
                c[0] = 0; c[1] = -d[2]; c[2] = d[1];
            end else begin
                c[0] = -d[1]; c[1] = d[0]; c[2] = 0;
            end
            ns = root(c[0]*c[0] + c[1]*c[1] + c[2]*c[2]);
            for (int i = 0; i < 3; i++) sd[i] = (ns == 0) ? 0 : round_div(c[i] * (1 << UF), ns);
            r[0] = round_div(sd[1]*a[2] - sd[2]*a[1], 1 << UF);
            r[1] = round_div(sd[2]*a[0] - sd[0]*a[2], 1 << UF);
            r[2] = round_div(sd[0]*a[1] - sd[1]*a[0], 1 << UF);
            nr = root(r[0]*r[0] + r[1]*r[1] + r[2]*r[2]);
            for (int i = 0; i < 3; i++) begin
                u[i] = (nr == 0) ? 0 : round_div(r[i] * (1 << UF), nr);
                s = round_div(d[i] * recip, longint'(1) << RECIP_FRAC);
                if (s > (longint'(1) << CW) - 1) s = (longint'(1) << CW) - 1;
                if (s < -(longint'(1) << CW)) s = -(longint'(1) << CW);
                f.side[i] = sd[i][UF+1:0];
                f.span[i] = s[CW:0];
                f.up[i]   = u[i][UF+1:0];
            end
            pending_frames.push_back(f);
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch on frame %0d: %s got %0h expected %0h",
                     frames_checked, what, got, want);
            errors++;
        endtask

        task check_frame(logic [OUT_W-1:0] data);
            frame_t want;
            if (pending_frames.size() == 0) begin
                report("unexpected frame", 0, 0);
                frames_checked++;
                return;
            end
            want = pending_frames.pop_front();
            for (int i = 0; i < 3; i++) begin
                if (data[i*CW+:CW] != want.org[i])
                    report($sformatf("origin[%0d]", i), data[i*CW+:CW], want.org[i]);
                if (data[3*CW+i*(UF+2)+:UF+2] != want.side[i])
                    report($sformatf("side[%0d]", i), data[3*CW+i*(UF+2)+:UF+2],
                           want.side[i]);
                if (data[3*CW+3*(UF+2)+i*(CW+1)+:CW+1] != want.span[i])
                    report($sformatf("span[%0d]", i),
                           data[3*CW+3*(UF+2)+i*(CW+1)+:CW+1], want.span[i]);
                if (data[6*CW+3+3*(UF+2)+i*(UF+2)+:UF+2] != want.up[i])
                    report($sformatf("up[%0d]", i),
                           data[6*CW+3+3*(UF+2)+i*(UF+2)+:UF+2], want.up[i]);
            end
            frames_checked++;
        endtask
    endclass

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic             s_tuser;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;
    logic             cfg_wr_en;
    logic [1:0]       cfg_index;
    logic [15:0]      cfg_data;

    frame_scoreboard sb;
    longint          cycles;
    bit              burst_mode;
    bit              held_off;

    segment_frame_builder dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial begin
        sb = new();
        cycles = 0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("** segment_frame_builder: FAILED **");
            $finish;
        end
    end

    // Beat monitor: samples both streams at each rising edge.
    always @(posedge clk) begin
        if (rst_n) begin
            if (s_tvalid && s_tready) sb.note_node(s_tdata, s_tuser);
            if (m_tvalid && m_tready) sb.check_frame(m_tdata);
        end
    end

    function int draw_gap();
        if (burst_mode) return 0;
        return $urandom_range(0, 19);
    endfunction

    // Output side: random stalls plus one long hold-off while nodes keep coming.
    initial begin
        int gap;
        m_tready = 0;
        held_off = 0;
        @(posedge rst_n);
        forever begin
            if (!held_off && sb.frames_checked >= 100) begin
                held_off = 1;
                m_tready <= 0;
                repeat (4000) @(posedge clk);
            end
            gap = draw_gap();
            if (gap > 0) begin
                m_tready <= 0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    task send_node(longint x, longint y, longint z, bit start_flag);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata  <= {3'b000, z[CW-1:0], y[CW-1:0], x[CW-1:0]};
        s_tuser  <= start_flag;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task drain();
        s_tvalid <= 0;
        while (sb.pending_frames.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task write_regs(logic [15:0] recip, logic [15:0] min_len, logic [15:0] sw);
        logic [1:0]  idx [4];
        logic [15:0] val [4];
        idx = '{REG_LENGTH_RECIP, REG_MIN_LENGTH, REG_AXIS_SWITCH, 2'd3};
        val = '{recip, min_len, sw, 16'hFFFF};
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en <= 1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            if (idx[i] != 2'd3) sb.set_reg(idx[i], val[i]);
        end
        cfg_wr_en <= 0;
        @(posedge clk);
    endtask

    function longint clampc(longint v);
        if (v > CMAX) return CMAX;
        if (v < CMIN) return CMIN;
        return v;
    endfunction

    function longint rand_coord();
        return longint'($signed(23'($urandom)));
    endfunction

    function longint rand_step(int scale);
        case (scale)
            0: return longint'($urandom_range(0, 8)) - 4;
            1: return longint'($urandom_range(0, 600)) - 300;
            2: return longint'($urandom_range(0, 40000)) - 20000;
            default: return rand_coord();
        endcase
    endfunction

    // Random ropes: mostly continuous runs, with occasional stray starts.
    task random_ropes(int count);
        longint x, y, z;
        int     n, scale;
        bit     vert;
        n = 0;
        while (n < count) begin
            x = rand_coord(); y = rand_coord(); z = rand_coord();
            if ((n / 50) % 3 == 0) burst_mode = 1;
            else burst_mode = 0;
            send_node(x, y, z, 1);
            n++;
            for (int k = $urandom_range(1, 11); k > 0 && n < count; k--) begin
                scale = $urandom_range(0, 3);
                vert  = ($urandom_range(0, 3) == 0);
                if (vert) begin
                    x = clampc(x + rand_step(0));
                    y = clampc(y + rand_step(0));
                end else begin
                    x = clampc(x + rand_step(scale));
                    y = clampc(y + rand_step(scale));
                end
                z = clampc(z + rand_step(scale));
                send_node(x, y, z, $urandom_range(0, 15) == 0);
                n++;
            end
        end
        burst_mode = 0;
    endtask

    initial begin
        rst_n     = 0;
        s_tvalid  = 0;
        s_tdata   = '0;
        s_tuser   = 0;
        cfg_wr_en = 0;
        cfg_index = '0;
        cfg_data  = '0;
        burst_mode = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Reset settings: no-history start, pure x, zero length, vertical, extremes.
        send_node(100, 200, 300, 0);
        send_node(1100, 200, 300, 0);
        send_node(1100, 200, 300, 0);
        send_node(1100, 200, 5300, 0);
        send_node(1101, 200, 5300, 0);
        send_node(CMAX, CMAX, CMAX, 1);
        send_node(CMIN, CMIN, CMIN, 0);
        send_node(CMAX, CMIN, CMAX, 0);
        send_node(0, 0, -20000, 0);
        send_node(5, -7, 3, 1);
        drain();

        // Full recip, no minimum, x reference always (upper bit ignored).
        write_regs(16'hFFFF, 16'd0, 16'h8000);
        send_node(0, 0, 0, 1);
        send_node(3000, 0, 0, 0);
        send_node(3000, 0, 0, 0);
        send_node(CMIN, CMAX, CMIN, 0);
        send_node(CMAX, CMIN, CMAX, 0);
        send_node(CMAX, CMIN + 1, CMAX - 40, 0);
        drain();

        // Zero recip, largest minimum, switch above unity so vertical degenerates.
        write_regs(16'd0, 16'hFFFF, 16'hFFFF);
        send_node(0, 0, 0, 1);
        send_node(0, 0, 100000, 0);
        send_node(1000, 0, 100000, 0);
        send_node(CMIN, 0, 100000, 0);
        drain();

        write_regs(16'($urandom_range(1, 65535)), 16'($urandom_range(0, 300)), 16'd14746);
        random_ropes(500);
        drain();

        write_regs(16'd1, 16'($urandom_range(0, 3000)), 16'($urandom_range(0, 16384)));
        random_ropes(500);
        drain();

        $display("covered %0d nodes and %0d frames over five register settings",
                 sb.nodes_seen, sb.frames_checked);
        if (sb.errors == 0 && sb.pending_frames.size() == 0)
            $display("** segment_frame_builder: PASSED **");
        else
            $display("** segment_frame_builder: FAILED **");
        $finish;
    end
endmodule

### files.f
hw/rtl/segfb_pkg.sv
hw/rtl/segfb_ctrl.sv
hw/rtl/segfb_dp.sv
hw/rtl/segment_frame_builder.sv
sim/testbench.sv
